// ----- rtl/rple_pkg.sv -----
// Package for the RGB pixel run-length encoder.
// Holds the record type, queue sizing and record packing shared by all rtl files.
`default_nettype none

package rple_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned REC_DEPTH   = 4;
  localparam int unsigned REC_PTR_W   = $clog2(REC_DEPTH);
  localparam int unsigned REC_LEVEL_W = $clog2(REC_DEPTH + 1);
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] MAX_RUN_RST = '1;

  typedef struct packed {
    logic               last;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COUNT_W-1:0] count;
  } rec_t;

  // queue status seen by the encoder core
  typedef struct packed {
    logic [REC_LEVEL_W-1:0] level;
    logic                   room2;
  } rec_stat_t;

  function automatic logic [OUT_DATA_W-1:0] pack_rec(input rec_t r);
    return {r.red, r.green, r.blue, r.count};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rple_rec_queue.sv -----
// Small record queue between the encoder and the output channel.
// Takes up to two records per cycle, hands out one; depends on rple_pkg.
`default_nettype none

module rple_rec_queue
  import rple_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_a,
  input  wire logic      push_b,
  input  wire rec_t      rec_a,
  input  wire rec_t      rec_b,
  input  wire logic      pop,
  output rec_t           head,
  output logic           head_valid,
  output rec_stat_t      stat
);

  rec_t                   entries [REC_DEPTH];
  logic [REC_PTR_W-1:0]   wptr;
  logic [REC_PTR_W-1:0]   rptr;
  logic [REC_LEVEL_W-1:0] level;
  logic [REC_PTR_W-1:0]   wptr_next;
  logic [REC_PTR_W-1:0]   wptr_b;
  logic [REC_LEVEL_W-1:0] level_next;
  logic [1:0]             push_n;

  assign push_n     = {1'b0, push_a} + {1'b0, push_b};
  assign wptr_b     = wptr + REC_PTR_W'(1);
  assign wptr_next  = wptr + REC_PTR_W'(push_n);
  assign level_next = level + REC_LEVEL_W'(push_n) - REC_LEVEL_W'(pop);

  assign head       = entries[rptr];
  assign head_valid = (level != '0);
  assign stat.level = level;
  assign stat.room2 = (level <= REC_LEVEL_W'(REC_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr_next;
      level <= level_next;
      if (pop) begin
        rptr <= rptr + REC_PTR_W'(1);
      end
    end
  end

  // a lone record goes to the write pointer whichever slot it came from
  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wptr] <= rec_a;
      if (push_b) begin
        entries[wptr_b] <= rec_b;
      end
    end else if (push_b) begin
      entries[wptr] <= rec_b;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rgb_pixel_run_length_encoder.sv -----
// RGB pixel run-length encoder, top level.
// Depends on rple_pkg and rple_rec_queue.
//
// Usage:
//   s_axis: one pixel per request, tdata = {blue, green, red} (red in the low
//   byte), tlast marks the last pixel of a tile.
//   m_axis: one record per request, tdata = {out_red, out_green, out_blue,
//   run_count} (run_count in the low byte), tlast marks the tile's final record.
//   cfg_we/cfg_wdata write max_run_length (reset 255); write only while idle.
// Timing:
//   A pixel is folded into the open run in the cycle it is accepted; its
//   records are written into a four-entry queue whose head drives m_axis.
//   One pixel per cycle is taken while the queue has room for two records,
//   so the rate is one pixel per cycle whenever the sink takes one record
//   per cycle; a pixel that closes the open run and whose own run is also
//   flushed (tile end or maximum) makes two records for the output side.
// Reset: no run open, queue empty, max_run_length = 255.
// Stall: when m_axis_tready is low the queue fills and s_axis_tready drops
//   once fewer than two slots are free; nothing is lost.
`default_nettype none

module rgb_pixel_run_length_encoder
  import rple_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [COUNT_W-1:0]    cfg_wdata,     // max_run_length
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // red, green, blue
  input  wire logic                  s_axis_tlast,  // last_pixel
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // run_count, out_blue, out_green, out_red
  output logic                       m_axis_tlast   // last_record
);

  logic [COUNT_W-1:0] max_run_length;
  logic [CHAN_W-1:0]  held_red;
  logic [CHAN_W-1:0]  held_green;
  logic [CHAN_W-1:0]  held_blue;
  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] held_count_next;

  logic [CHAN_W-1:0]  in_red;
  logic [CHAN_W-1:0]  in_green;
  logic [CHAN_W-1:0]  in_blue;
  logic               s_fire;
  logic               m_fire;
  logic               run_open;
  logic               differ;
  logic               new_run;
  logic [COUNT_W-1:0] run_count;
  logic               flush;
  rec_t               rec_old;
  rec_t               rec_cur;
  rec_t               head;
  logic               head_valid;
  rec_stat_t          stat;

  assign in_red   = s_axis_tdata[CHAN_W-1:0];
  assign in_green = s_axis_tdata[2*CHAN_W-1:CHAN_W];
  assign in_blue  = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

  assign s_axis_tready = stat.room2;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign run_open = (held_count != '0);
  assign differ   = (in_red != held_red) || (in_green != held_green) ||
                    (in_blue != held_blue);
  assign new_run  = !run_open || differ;

  // count saturates at 255; no open run gets that far, as a count of 255 always flushes
  always_comb begin
    if (new_run) begin
      run_count = COUNT_W'(1);
    end else if (held_count != COUNT_MAX) begin
      run_count = held_count + COUNT_W'(1);
    end else begin
      run_count = COUNT_MAX;
    end
  end

  assign flush           = (run_count >= max_run_length) || s_axis_tlast;
  assign held_count_next = flush ? '0 : run_count;

  always_comb begin
    rec_old.last  = 1'b0;
    rec_old.red   = held_red;
    rec_old.green = held_green;
    rec_old.blue  = held_blue;
    rec_old.count = held_count;
    rec_cur.last  = s_axis_tlast;
    rec_cur.red   = new_run ? in_red   : held_red;
    rec_cur.green = new_run ? in_green : held_green;
    rec_cur.blue  = new_run ? in_blue  : held_blue;
    rec_cur.count = run_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_length <= MAX_RUN_RST;
      held_count     <= '0;
      held_red       <= '0;
      held_green     <= '0;
      held_blue      <= '0;
    end else begin
      if (cfg_we) begin
        max_run_length <= cfg_wdata;
      end
      if (s_fire) begin
        held_count <= held_count_next;
        held_red   <= rec_cur.red;
        held_green <= rec_cur.green;
        held_blue  <= rec_cur.blue;
      end
    end
  end

  rple_rec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (s_fire && run_open && differ),
    .push_b     (s_fire && flush),
    .rec_a      (rec_old),
    .rec_b      (rec_cur),
    .pop        (m_fire),
    .head       (head),
    .head_valid (head_valid),
    .stat       (stat)
  );

  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = pack_rec(head);
  assign m_axis_tlast  = head.last;

  // an open run never reaches 255: reaching the maximum flushes it
  a_held_below_max: assert property (@(posedge clk) disable iff (rst)
    held_count != COUNT_MAX)
    else $error("open run count reached 255");

  a_tile_end_closes: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tlast |=> held_count == '0)
    else $error("run left open after last pixel");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    stat.level <= REC_LEVEL_W'(REC_DEPTH))
    else $error("record queue overflow");

  a_accept_has_room: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> stat.level <= REC_LEVEL_W'(REC_DEPTH))
    else $error("pixel accepted without room for its records");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for rgb_pixel_run_length_encoder: a directed table, then random runs.
// Depends on rple_pkg (rec_t, widths) and the rtl top; predicts every record in-line.
`default_nettype none

module tb_top;
  import rple_pkg::*;

  typedef enum logic {ROW_PIXEL, ROW_SET_MAX} row_kind_e;

  // typed rows fix count and last of the final record that the row causes
  typedef struct packed {
    row_kind_e         kind;
    logic [7:0]        max_len;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
    logic              typed;
    logic [7:0]        want_count;
    logic              want_last;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam int RANDOM_PIXELS = 1430;
  localparam int QUIET_AFTER = 1280;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // red, green, blue
  logic s_axis_tlast = 1'b0;                 // last_pixel
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // run_count, out_blue, out_green, out_red
  logic m_axis_tlast;                        // last_record

  // encoder image
  logic [7:0] run_max;
  logic [7:0] run_red, run_green, run_blue;
  logic [7:0] run_len;

  rec_t pending_records[$];
  int errors = 0;
  int pixels_sent = 0;
  int records_seen = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{ROW_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_PIXEL,   8'd0,   8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 8'd3, 1'b1},
    '{ROW_PIXEL,   8'd0,   8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h65, 8'h43, 8'h21, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_SET_MAX, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'haa, 8'h55, 8'haa, 1'b0, 1'b1, 8'd1, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'haa, 8'h55, 8'haa, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_SET_MAX, 8'd1,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h01, 8'h02, 8'h03, 1'b0, 1'b1, 8'd1, 1'b0},
    '{ROW_SET_MAX, 8'd3,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 8'd3, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 8'd0, 1'b0},
    // differing pixel that also ends the tile: two records
    '{ROW_PIXEL,   8'd0,   8'h7f, 8'h7f, 8'h7f, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_SET_MAX, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h11, 8'h11, 8'h11, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h11, 8'h11, 8'h11, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h11, 8'h11, 8'h11, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h11, 8'h11, 8'h11, 1'b0, 1'b0, 8'd0, 1'b0},
    // max lowered under an open run of four: next joining pixel flushes five
    '{ROW_SET_MAX, 8'd2,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h11, 8'h11, 8'h11, 1'b0, 1'b1, 8'd5, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h5a, 8'h5a, 8'h5a, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h5a, 8'h5a, 8'h5a, 1'b0, 1'b1, 8'd2, 1'b0},
    '{ROW_PIXEL,   8'd0,   8'h5a, 8'h5a, 8'h5a, 1'b1, 1'b1, 8'd1, 1'b1}
  };

  rgb_pixel_run_length_encoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch on record %0d: %s got %0d want %0d", records_seen, what, got, want);
  endtask

  // folds one pixel into the open run and queues the records it closes
  task automatic encode_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic last, output int n);
    rec_t rec;
    n = 0;
    if (run_len != 0 && (r != run_red || g != run_green || b != run_blue)) begin
      rec = '{last: 1'b0, red: run_red, green: run_green, blue: run_blue, count: run_len};
      pending_records.push_back(rec);
      n++;
      run_len = 0;
    end
    if (run_len == 0) begin
      run_red = r;
      run_green = g;
      run_blue = b;
      run_len = 8'd1;
    end else if (run_len != COUNT_MAX) begin
      run_len = run_len + 8'd1;
    end
    if (run_len >= run_max || last) begin
      rec = '{last: last, red: run_red, green: run_green, blue: run_blue, count: run_len};
      pending_records.push_back(rec);
      n++;
      run_len = 0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last, output int n);
    s_axis_tdata <= {b, g, r};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    encode_pixel(r, g, b, last, n);
    pixels_sent++;
    if (pixels_sent >= QUIET_AFTER)
      quiet = 1'b1;
    if (!quiet && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
  endtask

  // sender holds off until every queued record is out, then the core is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [7:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_max = value;
  endtask

  // a run of one colour, closed by last now and then; some sizes sit at the max edges
  task automatic random_run(inout logic [23:0] prev_pix);
    logic [23:0] pix;
    int len;
    int pick;
    int n;
    logic last;
    pick = $urandom_range(9);
    if (pick == 0)
      pix = 24'h000000;
    else if (pick == 1)
      pix = 24'hffffff;
    else if (pick == 2)
      pix = prev_pix;
    else
      pix = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 65)
      len = $urandom_range(6, 1);
    else if (pick < 85)
      len = $urandom_range(int'(run_max) + 1, (run_max > 1) ? int'(run_max) - 1 : 1);
    else if (pick < 97)
      len = $urandom_range(40, 7);
    else
      len = $urandom_range(300, 200);
    // keep the total close to the planned pixel count
    if (len > RANDOM_PIXELS - pixels_sent)
      len = RANDOM_PIXELS - pixels_sent;
    last = ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      send_pixel(pix[7:0], pix[15:8], pix[23:16],
                 (i == len - 1) ? last : ($urandom_range(99) < 2), n);
    end
    prev_pix = pix;
  endtask

  // sink side: random stall bursts, then a plain drain in the quiet tail
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        report("unexpected record, tdata", int'(m_axis_tdata), 0);
      end else begin
        rec_t want;
        want = pending_records.pop_front();
        if (m_axis_tdata[7:0] != want.count)
          report("run_count", int'(m_axis_tdata[7:0]), int'(want.count));
        if (m_axis_tdata[15:8] != want.blue)
          report("out_blue", int'(m_axis_tdata[15:8]), int'(want.blue));
        if (m_axis_tdata[23:16] != want.green)
          report("out_green", int'(m_axis_tdata[23:16]), int'(want.green));
        if (m_axis_tdata[31:24] != want.red)
          report("out_red", int'(m_axis_tdata[31:24]), int'(want.red));
        if (m_axis_tlast != want.last)
          report("last_record", int'(m_axis_tlast), int'(want.last));
      end
      records_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(9, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int n;
    int phase;
    int phase_end;
    logic [23:0] prev_pix;
    rec_t tail;
    run_max = MAX_RUN_RST;
    run_red = '0;
    run_green = '0;
    run_blue = '0;
    run_len = '0;
    prev_pix = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_SET_MAX) begin
        write_max(dir_table[i].max_len);
      end else begin
        send_pixel(dir_table[i].red, dir_table[i].green, dir_table[i].blue,
                   dir_table[i].last, n);
        if (dir_table[i].typed && n > 0) begin
          tail = pending_records.pop_back();
          tail.count = dir_table[i].want_count;
          tail.last = dir_table[i].want_last;
          pending_records.push_back(tail);
        end
      end
    end

    phase = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case (phase)
        0: write_max(8'd1);
        1: write_max(8'd255);
        2: write_max(8'd0);
        3: write_max(8'd2);
        default: write_max(8'($urandom_range(255, 1)));
      endcase
      gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(40);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(40);
      phase_end = pixels_sent + $urandom_range(140, 60);
      while (pixels_sent < phase_end && pixels_sent < RANDOM_PIXELS) begin
        if ($urandom_range(9) == 0) begin
          prev_pix = 24'($urandom);
          send_pixel(prev_pix[7:0], prev_pix[15:8], prev_pix[23:16],
                     1'($urandom_range(1)), n);
        end else begin
          random_run(prev_pix);
        end
      end
      phase++;
    end

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0)
      $display("PASS rgb_pixel_run_length_encoder");
    else
      $display("FAIL rgb_pixel_run_length_encoder");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL rgb_pixel_run_length_encoder");
    $finish;
  end

endmodule

`default_nettype wire
